### src/ishs_pkg.sv
`default_nettype none

package ishs_pkg;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_NAME,
    PH_TAIL,
    PH_ACCEPT,
    PH_REJECT
  } phase_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

endpackage

`default_nettype wire

### src/ishs_ifs.sv
`default_nettype none

interface ishs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_of_buffer;

  modport source (output valid, output text_byte, output last_of_buffer, input ready);
  modport sink   (input valid, input text_byte, input last_of_buffer, output ready);
endinterface

interface ishs_out_if;
  logic       valid;
  logic       ready;
  logic       is_section;
  logic [7:0] name_offset;
  logic [7:0] name_length;
  logic [7:0] line_length;
  logic       line_too_long;

  modport source (output valid, output is_section, output name_offset, output name_length,
                  output line_length, output line_too_long, input ready);
  modport sink   (input valid, input is_section, input name_offset, input name_length,
                  input line_length, input line_too_long, output ready);
endinterface

`default_nettype wire

### src/ini_section_header_scanner_core.sv
// INI section header scanner.
// text (sink): one byte of the INI buffer per item, with last_of_buffer on the
//   final byte. CR or LF closes the open line; runs of them give nothing.
// result (source): one item per finished line: section flag, trimmed name
//   offset and length, line length (saturated at MAX_LINE) and overflow flag.
// Throughput: one byte per cycle when not stalled. Each byte lands in an input
//   register, and from there a single pass of phase logic updates the line
//   state and, on a line end, loads the result register and raises
//   result.valid.
// Stall: a held result blocks only a byte that would end a line; other bytes
//   keep flowing. When the input register cannot drain, text.ready drops.
// Reset (rst, synchronous): clears the line state to the leading-blanks
//   phase, empties the input register and drops result.valid.
// An open line still pending when last_of_buffer arrives is dropped.
`default_nettype none

module ini_section_header_scanner_core #(
  parameter int MAX_LINE = 255
) (
  input  wire         clk,
  input  wire         rst,
  ishs_in_if.sink     text,
  ishs_out_if.source  result
);

  localparam int POS_W = $clog2(MAX_LINE + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LINE);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // line state
  ishs_pkg::phase_t phase, phase_next;
  logic             line_open, line_open_next;
  logic [POS_W-1:0] position, position_next;
  logic [POS_W-1:0] name_first, name_first_next;
  logic [POS_W-1:0] name_stop, name_stop_next;
  logic             name_seen, name_seen_next;
  logic             overflowed, overflowed_next;

  // result register
  logic       res_valid;
  logic       res_is_section;
  logic [7:0] res_name_offset;
  logic [7:0] res_name_length;
  logic [7:0] res_line_length;
  logic       res_line_too_long;

  logic             is_blank, is_term, emit, sect, advance;
  logic [POS_W-1:0] pos_inc;

  assign is_blank = (s1_byte == ishs_pkg::CH_SPACE) || (s1_byte == ishs_pkg::CH_TAB);
  assign is_term  = (s1_byte == ishs_pkg::CH_CR) || (s1_byte == ishs_pkg::CH_LF);
  assign emit     = is_term && line_open;
  assign sect     = !overflowed &&
                    (phase == ishs_pkg::PH_TAIL || phase == ishs_pkg::PH_ACCEPT);
  assign pos_inc  = position + 1'b1;

  // a byte that makes no result never waits on the output side
  assign advance    = s1_valid && (!emit || !res_valid || result.ready);
  assign text.ready = !s1_valid || advance;

  always_comb begin
    phase_next      = phase;
    line_open_next  = line_open;
    position_next   = position;
    name_first_next = name_first;
    name_stop_next  = name_stop;
    name_seen_next  = name_seen;
    overflowed_next = overflowed;

    if (is_term) begin
      phase_next      = ishs_pkg::PH_LEAD;
      line_open_next  = 1'b0;
      position_next   = '0;
      name_first_next = '0;
      name_stop_next  = '0;
      name_seen_next  = 1'b0;
      overflowed_next = 1'b0;
    end else begin
      line_open_next = 1'b1;
      if (position >= MAX_POS) begin
        overflowed_next = 1'b1;
      end else begin
        unique case (phase)
          ishs_pkg::PH_LEAD: begin
            if (s1_byte == ishs_pkg::CH_LBRACK) begin
              phase_next      = ishs_pkg::PH_NAME;
              name_first_next = pos_inc;
              name_stop_next  = pos_inc;
            end else if (!is_blank) begin
              phase_next = ishs_pkg::PH_REJECT;
            end
          end
          ishs_pkg::PH_NAME: begin
            if (s1_byte == ishs_pkg::CH_RBRACK) begin
              if (!name_seen) name_stop_next = position;
              phase_next = ishs_pkg::PH_TAIL;
            end else if (s1_byte == ishs_pkg::CH_SEMI || s1_byte == ishs_pkg::CH_HASH ||
                         s1_byte == ishs_pkg::CH_NUL) begin
              phase_next = ishs_pkg::PH_REJECT;
            end else if (is_blank) begin
              if (!name_seen) name_first_next = pos_inc;
            end else begin
              name_seen_next = 1'b1;
              name_stop_next = pos_inc;
            end
          end
          ishs_pkg::PH_TAIL: begin
            if (s1_byte == ishs_pkg::CH_SEMI || s1_byte == ishs_pkg::CH_HASH ||
                s1_byte == ishs_pkg::CH_NUL) begin
              phase_next = ishs_pkg::PH_ACCEPT;
            end else if (!is_blank) begin
              phase_next = ishs_pkg::PH_REJECT;
            end
          end
          default: ;
        endcase
        if (s1_byte == ishs_pkg::CH_NUL && phase_next != ishs_pkg::PH_ACCEPT) begin
          phase_next = ishs_pkg::PH_REJECT;
        end
        position_next = pos_inc;
      end
      // unterminated tail of the buffer is thrown away
      if (s1_last) begin
        phase_next      = ishs_pkg::PH_LEAD;
        line_open_next  = 1'b0;
        position_next   = '0;
        name_first_next = '0;
        name_stop_next  = '0;
        name_seen_next  = 1'b0;
        overflowed_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
    if (text.ready) begin
      s1_byte <= text.text_byte;
      s1_last <= text.last_of_buffer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ishs_pkg::PH_LEAD;
      line_open  <= 1'b0;
      position   <= '0;
      name_first <= '0;
      name_stop  <= '0;
      name_seen  <= 1'b0;
      overflowed <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      line_open  <= line_open_next;
      position   <= position_next;
      name_first <= name_first_next;
      name_stop  <= name_stop_next;
      name_seen  <= name_seen_next;
      overflowed <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (advance && emit) begin
      res_is_section    <= sect;
      res_name_offset   <= sect ? 8'(name_first) : 8'd0;
      res_name_length   <= sect ? 8'(name_stop - name_first) : 8'd0;
      res_line_length   <= 8'(position);
      res_line_too_long <= overflowed;
    end
  end

  assign result.valid         = res_valid;
  assign result.is_section    = res_is_section;
  assign result.name_offset   = res_name_offset;
  assign result.name_length   = res_name_length;
  assign result.line_length   = res_line_length;
  assign result.line_too_long = res_line_too_long;

  a_closed_line_clean: assert property (@(posedge clk) disable iff (rst)
    !line_open |-> (position == '0 && phase == ishs_pkg::PH_LEAD && !overflowed))
    else $error("closed line carries stale state");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position <= MAX_POS)
    else $error("line position beyond maximum");

  a_overflow_saturates: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> position == MAX_POS)
    else $error("overflow flagged below maximum");

  a_name_order: assert property (@(posedge clk) disable iff (rst)
    (phase == ishs_pkg::PH_TAIL || phase == ishs_pkg::PH_ACCEPT) |-> name_stop >= name_first)
    else $error("name stop precedes name start");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> res_valid)
    else $error("finished line lost its result");

endmodule

`default_nettype wire

### tb/sv/tb_ini_section_header_scanner_core.sv
`timescale 1ns / 1ps

module tb_ini_section_header_scanner_core;

  localparam int MAX_LINE     = 255;
  localparam int RANDOM_BYTES = 750;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIR_ROWS     = 24;
  localparam int TIMEOUT_NS   = 5_000_000;

  typedef struct packed {
    logic       is_section;
    logic [7:0] name_offset;
    logic [7:0] name_length;
    logic [7:0] line_length;
    logic       line_too_long;
  } line_result_t;

  typedef struct packed {
    logic [7:0]   text_byte;
    logic         last;
    logic         fixed;
    line_result_t want;
  } text_item_t;

  localparam line_result_t NO_RES = '0;

  logic clk;
  logic rst;

  ishs_in_if  text_if ();
  ishs_out_if res_if ();

  ini_section_header_scanner_core #(.MAX_LINE(MAX_LINE)) dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if),
    .result (res_if)
  );

  // Scanner state mirrored by the predictor
  ishs_pkg::phase_t ln_phase;
  bit               ln_open;
  int unsigned      ln_pos;
  int unsigned      ln_first;
  int unsigned      ln_stop;
  bit               ln_named;
  bit               ln_over;

  text_item_t   byte_stream[$];
  line_result_t pending_lines[$];
  int           errors = 0;
  int           lines_checked = 0;

  // Directed lines; the fixed rows carry results read straight off the rules.
  text_item_t directed_rows [DIR_ROWS] = '{
    // "[]" : empty name, offset points at ']'
    '{ishs_pkg::CH_LBRACK, 1'b0, 1'b0, NO_RES},
    '{ishs_pkg::CH_RBRACK, 1'b0, 1'b0, NO_RES},
    '{ishs_pkg::CH_LF,     1'b0, 1'b1, '{1'b1, 8'd1, 8'd0, 8'd2, 1'b0}},
    // "[<nul>]" : zero byte inside the name kills the header
    '{ishs_pkg::CH_LBRACK, 1'b0, 1'b0, NO_RES},
    '{ishs_pkg::CH_NUL,    1'b0, 1'b0, NO_RES},
    '{ishs_pkg::CH_RBRACK, 1'b0, 1'b0, NO_RES},
    '{ishs_pkg::CH_LF,     1'b0, 1'b1, '{1'b0, 8'd0, 8'd0, 8'd3, 1'b0}},
    // "[k]<nul><ff>" CR LF : zero after ']' accepts, rest ignored
    '{ishs_pkg::CH_LBRACK, 1'b0, 1'b0, NO_RES},
    '{8'h6B,               1'b0, 1'b0, NO_RES},
    '{ishs_pkg::CH_RBRACK, 1'b0, 1'b0, NO_RES},
    '{ishs_pkg::CH_NUL,    1'b0, 1'b0, NO_RES},
    '{8'hFF,               1'b0, 1'b0, NO_RES},
    '{ishs_pkg::CH_CR,     1'b0, 1'b1, '{1'b1, 8'd1, 8'd1, 8'd5, 1'b0}},
    '{ishs_pkg::CH_LF,     1'b0, 1'b0, NO_RES},
    // tab then junk: plain line
    '{ishs_pkg::CH_TAB,    1'b0, 1'b0, NO_RES},
    '{8'hFF,               1'b0, 1'b0, NO_RES},
    '{ishs_pkg::CH_LF,     1'b0, 1'b1, '{1'b0, 8'd0, 8'd0, 8'd2, 1'b0}},
    // "[a" : no closing bracket
    '{ishs_pkg::CH_LBRACK, 1'b0, 1'b0, NO_RES},
    '{8'h61,               1'b0, 1'b0, NO_RES},
    '{ishs_pkg::CH_LF,     1'b0, 1'b1, '{1'b0, 8'd0, 8'd0, 8'd2, 1'b0}},
    // " [x" ends the buffer unterminated, so it is dropped
    '{ishs_pkg::CH_SPACE,  1'b0, 1'b0, NO_RES},
    '{ishs_pkg::CH_LBRACK, 1'b0, 1'b0, NO_RES},
    '{8'h78,               1'b1, 1'b0, NO_RES},
    '{ishs_pkg::CH_LF,     1'b0, 1'b0, NO_RES}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_line();
    ln_phase = ishs_pkg::PH_LEAD;
    ln_open  = 1'b0;
    ln_pos   = 0;
    ln_first = 0;
    ln_stop  = 0;
    ln_named = 1'b0;
    ln_over  = 1'b0;
  endfunction

  // Advances the line state by one byte; returns 1 when a line result is due.
  function automatic bit scan_line_byte(input logic [7:0] c, input logic last,
                                        output line_result_t r);
    bit blank;
    bit sect;
    bit got;
    got   = 1'b0;
    r     = NO_RES;
    blank = (c == ishs_pkg::CH_SPACE) || (c == ishs_pkg::CH_TAB);
    if (c == ishs_pkg::CH_CR || c == ishs_pkg::CH_LF) begin
      if (ln_open) begin
        sect            = !ln_over && (ln_phase == ishs_pkg::PH_TAIL ||
                                       ln_phase == ishs_pkg::PH_ACCEPT);
        r.is_section    = sect;
        r.name_offset   = sect ? ln_first[7:0] : 8'd0;
        r.name_length   = sect ? 8'(ln_stop - ln_first) : 8'd0;
        r.line_length   = ln_pos[7:0];
        r.line_too_long = ln_over;
        got             = 1'b1;
        clear_line();
      end
    end else begin
      ln_open = 1'b1;
      if (ln_pos >= MAX_LINE) begin
        ln_over = 1'b1;
        ln_pos  = MAX_LINE;
      end else begin
        case (ln_phase)
          ishs_pkg::PH_LEAD: begin
            if (c == ishs_pkg::CH_LBRACK) begin
              ln_phase = ishs_pkg::PH_NAME;
              ln_first = ln_pos + 1;
              ln_stop  = ln_pos + 1;
            end else if (!blank) begin
              ln_phase = ishs_pkg::PH_REJECT;
            end
          end
          ishs_pkg::PH_NAME: begin
            if (c == ishs_pkg::CH_RBRACK) begin
              if (!ln_named) ln_stop = ln_pos;
              ln_phase = ishs_pkg::PH_TAIL;
            end else if (c == ishs_pkg::CH_SEMI || c == ishs_pkg::CH_HASH ||
                         c == ishs_pkg::CH_NUL) begin
              ln_phase = ishs_pkg::PH_REJECT;
            end else if (blank) begin
              // leading blanks push the name start along
              if (!ln_named) ln_first = ln_pos + 1;
            end else begin
              ln_named = 1'b1;
              ln_stop  = ln_pos + 1;
            end
          end
          ishs_pkg::PH_TAIL: begin
            if (c == ishs_pkg::CH_SEMI || c == ishs_pkg::CH_HASH || c == ishs_pkg::CH_NUL)
              ln_phase = ishs_pkg::PH_ACCEPT;
            else if (!blank) ln_phase = ishs_pkg::PH_REJECT;
          end
          default: ;
        endcase
        if (c == ishs_pkg::CH_NUL && ln_phase != ishs_pkg::PH_ACCEPT)
          ln_phase = ishs_pkg::PH_REJECT;
        ln_pos++;
      end
    end
    if (last && ln_open) clear_line();
    return got;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    byte_stream.push_back('{b, 1'b0, 1'b0, NO_RES});
  endfunction

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 1) != 0) ? ishs_pkg::CH_SPACE : ishs_pkg::CH_TAB;
  endfunction

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ishs_pkg::CH_CR || c == ishs_pkg::CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] pick_name_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == ishs_pkg::CH_RBRACK || c == ishs_pkg::CH_SEMI || c == ishs_pkg::CH_HASH ||
           c == ishs_pkg::CH_CR || c == ishs_pkg::CH_LF || c == ishs_pkg::CH_SPACE ||
           c == ishs_pkg::CH_TAB);
    return c;
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 7))
      0: return ishs_pkg::CH_LBRACK;
      1: return ishs_pkg::CH_RBRACK;
      2: return ishs_pkg::CH_SEMI;
      3: return ishs_pkg::CH_HASH;
      4: return ishs_pkg::CH_NUL;
      5: return ishs_pkg::CH_SPACE;
      6: return ishs_pkg::CH_TAB;
      default: return pick_text_byte();
    endcase
  endfunction

  // Mostly well-formed headers with random content, some broken, some noise,
  // plus a few lines around MAX_LINE.
  task automatic build_random_lines();
    int         made;
    int         lines;
    int         n;
    int         first;
    int         kind;
    logic [7:0] line_buf[$];
    made  = 0;
    lines = 0;
    while (made < RANDOM_BYTES) begin
      line_buf = {};
      kind     = $urandom_range(0, 99);
      if (lines == 6 || lines == 12) begin
        // one line right at the limit, one a few bytes past it
        n = (lines == 6) ? MAX_LINE : MAX_LINE + 3;
        line_buf = {ishs_pkg::CH_LBRACK, 8'h61, 8'h62, ishs_pkg::CH_RBRACK};
        while (line_buf.size() < n) line_buf.push_back(pick_blank());
      end else if (kind < 75) begin
        repeat ($urandom_range(0, 3)) line_buf.push_back(pick_blank());
        line_buf.push_back(ishs_pkg::CH_LBRACK);
        repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          line_buf.push_back(($urandom_range(0, 4) == 0) ? pick_blank() : pick_name_byte());
        repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
        line_buf.push_back(ishs_pkg::CH_RBRACK);
        repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
        case ($urandom_range(0, 3))
          0: line_buf.push_back(ishs_pkg::CH_SEMI);
          1: line_buf.push_back(ishs_pkg::CH_HASH);
          2: line_buf.push_back(ishs_pkg::CH_NUL);
          default: ;
        endcase
        repeat ($urandom_range(0, 5)) line_buf.push_back(pick_text_byte());
        if (kind >= 60) line_buf[$urandom_range(0, line_buf.size() - 1)] = pick_special();
      end else begin
        repeat ($urandom_range(0, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
      end

      first = byte_stream.size();
      foreach (line_buf[i]) add_byte(line_buf[i]);
      case ($urandom_range(0, 2))
        0: add_byte(ishs_pkg::CH_CR);
        1: add_byte(ishs_pkg::CH_LF);
        default: begin
          add_byte(ishs_pkg::CH_CR);
          add_byte(ishs_pkg::CH_LF);
        end
      endcase
      if ($urandom_range(0, 7) == 0) add_byte(ishs_pkg::CH_LF);
      if ($urandom_range(0, 24) == 0)
        byte_stream[$urandom_range(first, byte_stream.size() - 1)].last = 1'b1;
      made += byte_stream.size() - first;
      lines++;
    end
  endtask

  task automatic send_byte(input text_item_t s);
    line_result_t r;
    bit           got;
    @(negedge clk);
    text_if.valid          <= 1'b1;
    text_if.text_byte      <= s.text_byte;
    text_if.last_of_buffer <= s.last;
    do @(posedge clk);
    while (!text_if.ready);
    got = scan_line_byte(s.text_byte, s.last, r);
    if (s.fixed) pending_lines.push_back(s.want);
    else if (got) pending_lines.push_back(r);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      text_if.valid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    while (pending_lines.size() != 0) begin
      @(negedge clk);
      text_if.valid <= 1'b0;
    end
  endtask

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Sender
  initial begin
    int burst;
    int mid_pause;
    text_if.valid          = 1'b0;
    text_if.text_byte      = 8'd0;
    text_if.last_of_buffer = 1'b0;
    rst = 1'b1;
    clear_line();
    foreach (directed_rows[i]) byte_stream.push_back(directed_rows[i]);
    build_random_lines();
    mid_pause = byte_stream.size() / 2;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    burst = 0;
    for (int i = 0; i < byte_stream.size(); i++) begin
      if (i == DIR_ROWS || i == mid_pause) drain_results();
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 10));
      end
      burst--;
      send_byte(byte_stream[i]);
    end
    @(negedge clk);
    text_if.valid <= 1'b0;

    while (pending_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Receiver: rotating stall pattern, plus one long hold-off to back up the input
  initial begin
    int unsigned cyc;
    bit          held_off;
    res_if.ready = 1'b0;
    cyc          = 0;
    held_off     = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held_off && lines_checked >= 10) begin
        held_off = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          res_if.ready <= 1'b0;
        end
      end else begin
        cyc++;
        case ((cyc / 64) % 4)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 3) != 0);
          2: res_if.ready <= cyc[2];
          default: res_if.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Result checker
  initial begin
    line_result_t got;
    line_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        got = '{res_if.is_section, res_if.name_offset, res_if.name_length,
                res_if.line_length, res_if.line_too_long};
        if (pending_lines.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result: expected none, got %p", $time, got);
        end else begin
          want = pending_lines.pop_front();
          check_field("is_section", 8'(want.is_section), 8'(got.is_section));
          check_field("name_offset", want.name_offset, got.name_offset);
          check_field("name_length", want.name_length, got.name_length);
          check_field("line_length", want.line_length, got.line_length);
          check_field("line_too_long", 8'(want.line_too_long), 8'(got.line_too_long));
        end
        lines_checked++;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
src/ishs_pkg.sv
src/ishs_ifs.sv
src/ini_section_header_scanner_core.sv
tb/sv/tb_ini_section_header_scanner_core.sv
